FILE: hw/rtl/fmr_pkg.sv
package fmr_pkg;

	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int PIX_W      = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_BLOCK_SIZE   = 2'd2
	} cfg_reg_t;

	localparam int RST_FRAME_WIDTH  = 640;
	localparam int RST_FRAME_HEIGHT = 480;
	localparam int RST_BLOCK_SIZE   = 8;

	typedef logic [PIX_W-1:0] pixel_t;

	localparam pixel_t OPAQUE_BLACK = 32'hFF00_0000;

	// raster control for the pixel being transferred in
	typedef struct packed {
		logic line_rd;      // later row of a block: color comes from the line store
		logic block_start;  // top-left pixel of a block
		logic frame_end;    // last pixel of the frame
	} raster_ctl_t;

	typedef struct packed {
		pixel_t key;
		pixel_t value;
	} swap_pair_t;

	localparam int SWAP_LEN = 18;

	localparam swap_pair_t SWAP_TABLE [SWAP_LEN] = '{
		'{32'hFF008AFF, 32'hFF000000},
		'{32'hFF646464, 32'hFF404040},
		'{32'hFF787878, 32'hFF737373},
		'{32'hFFA5A08C, 32'hFF737373},
		'{32'hFF91873C, 32'hFFABABAB},
		'{32'hFF91873D, 32'hFFABABAB},
		'{32'hFF5A6423, 32'hFFABABAB},
		'{32'hFF75752F, 32'hFFABABAB},
		'{32'hFF784614, 32'hFF8D8D8D},
		'{32'hFF00FF00, 32'hFFCCCCCC},
		'{32'hFF400000, 32'hFF999999},
		'{32'hFFFF0000, 32'hFF999999},
		'{32'hFF7F0000, 32'hFFFFFFFF},
		'{32'hFFFF00FF, 32'hFFC0C0C0},
		'{32'hFFD2C8A0, 32'hFF666666},
		'{32'hFF8C460F, 32'hFF666666},
		'{32'hFFFF8000, 32'hFF808080},
		'{32'hFFDC6400, 32'hFF808080}
	};

	// keys are all distinct, so an AND-OR of the hits gives the single match
	function automatic pixel_t recolor(input pixel_t c);
		pixel_t acc;
		logic   any_hit;
		acc     = '0;
		any_hit = 1'b0;
		for (int i = 0; i < SWAP_LEN; i++) begin
			if (SWAP_TABLE[i].key == c) begin
				acc     = acc | SWAP_TABLE[i].value;
				any_hit = 1'b1;
			end
		end
		return any_hit ? acc : c;
	endfunction

endpackage

FILE: hw/rtl/fmr_line_store.sv
// One entry per block column; single port, registered read.
module fmr_line_store #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic                rd_en,
	input  logic [AW-1:0]       addr,
	input  fmr_pkg::pixel_t     wr_data,
	output fmr_pkg::pixel_t     rd_data
);

	fmr_pkg::pixel_t mem [DEPTH];
	fmr_pkg::pixel_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hw/rtl/fmr_raster.sv
// Raster and block position counters plus the size registers.
module fmr_raster #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096,
	parameter int CW         = $clog2(MAX_WIDTH),
	parameter int LW         = $clog2(MAX_HEIGHT)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [fmr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fmr_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              adv,
	output fmr_pkg::raster_ctl_t              ctl,
	output logic [CW-1:0]                     blk_idx
);

	localparam int DW  = $clog2(MAX_WIDTH + 1);
	localparam int HDW = $clog2(MAX_HEIGHT + 1);

	localparam int W_RST = (fmr_pkg::RST_FRAME_WIDTH > MAX_WIDTH) ?
		MAX_WIDTH : fmr_pkg::RST_FRAME_WIDTH;
	localparam int H_RST = (fmr_pkg::RST_FRAME_HEIGHT > MAX_HEIGHT) ?
		MAX_HEIGHT : fmr_pkg::RST_FRAME_HEIGHT;
	localparam int B_RST = (fmr_pkg::RST_BLOCK_SIZE > MAX_WIDTH) ?
		MAX_WIDTH : fmr_pkg::RST_BLOCK_SIZE;

	logic [DW-1:0]  wid_q;
	logic [HDW-1:0] hgt_q;
	logic [DW-1:0]  bsz_q;

	logic [CW-1:0] col_q;
	logic [LW-1:0] line_q;
	logic [CW-1:0] ox_q;
	logic [CW-1:0] oy_q;
	logic [CW-1:0] bidx_q;

	logic line_end;
	logic frame_end;
	logic ox_wrap;
	logic oy_wrap;

	// zero acts as one, oversize acts as the maximum
	function automatic logic [31:0] clamp_reg(input logic [fmr_pkg::CFG_DATA_W-1:0] v,
			input logic [31:0] hi);
		logic [31:0] v32;
		v32 = 32'(v);
		if (v32 == 32'd0) begin
			return 32'd1;
		end
		return (v32 > hi) ? hi : v32;
	endfunction

	assign line_end  = (DW'(col_q) + DW'(1)) >= wid_q;
	assign frame_end = line_end && ((HDW'(line_q) + HDW'(1)) >= hgt_q);
	assign ox_wrap   = (DW'(ox_q) + DW'(1)) >= bsz_q;
	assign oy_wrap   = (DW'(oy_q) + DW'(1)) >= bsz_q;

	assign ctl.line_rd     = (oy_q != '0);
	assign ctl.block_start = (oy_q == '0) && (ox_q == '0);
	assign ctl.frame_end   = frame_end;
	assign blk_idx         = bidx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wid_q  <= DW'(W_RST);
			hgt_q  <= HDW'(H_RST);
			bsz_q  <= DW'(B_RST);
			col_q  <= '0;
			line_q <= '0;
			ox_q   <= '0;
			oy_q   <= '0;
			bidx_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (fmr_pkg::cfg_reg_t'(cfg_index))
				fmr_pkg::REG_FRAME_WIDTH: begin
					wid_q <= DW'(clamp_reg(cfg_data, 32'(MAX_WIDTH)));
				end
				fmr_pkg::REG_FRAME_HEIGHT: begin
					hgt_q <= HDW'(clamp_reg(cfg_data, 32'(MAX_HEIGHT)));
				end
				fmr_pkg::REG_BLOCK_SIZE: begin
					bsz_q <= DW'(clamp_reg(cfg_data, 32'(MAX_WIDTH)));
				end
				default: begin
				end
			endcase
			// a write to a defined register restarts the frame
			if (cfg_index == fmr_pkg::REG_FRAME_WIDTH || cfg_index == fmr_pkg::REG_FRAME_HEIGHT
					|| cfg_index == fmr_pkg::REG_BLOCK_SIZE) begin
				col_q  <= '0;
				line_q <= '0;
				ox_q   <= '0;
				oy_q   <= '0;
				bidx_q <= '0;
			end
		end else if (adv) begin
			if (frame_end) begin
				col_q  <= '0;
				line_q <= '0;
				ox_q   <= '0;
				oy_q   <= '0;
				bidx_q <= '0;
			end else if (line_end) begin
				col_q  <= '0;
				ox_q   <= '0;
				bidx_q <= '0;
				line_q <= line_q + LW'(1);
				oy_q   <= oy_wrap ? '0 : oy_q + CW'(1);
			end else begin
				col_q <= col_q + CW'(1);
				if (ox_wrap) begin
					ox_q   <= '0;
					bidx_q <= bidx_q + CW'(1);
				end else begin
					ox_q <= ox_q + CW'(1);
				end
			end
		end
	end

	a_frame_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !cfg_wr_en && frame_end) |=> (col_q == '0 && line_q == '0 && oy_q == '0))
		else $error("raster did not restart after last pixel");

	a_store_rw_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.line_rd && ctl.block_start))
		else $error("line store write and read selected together");

	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !cfg_wr_en && !line_end) |=> (col_q == $past(col_q) + CW'(1)))
		else $error("column counter skipped");

endmodule

FILE: hw/rtl/fmr_out_stage.sv
// Palette swap and output register.
module fmr_out_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  fmr_pkg::pixel_t colour,
	input  logic            last,
	input  logic            out_stall,
	output logic            out_valid,
	output fmr_pkg::pixel_t pixel_out,
	output logic            frame_last,
	output logic            ready
);

	logic            valid_q;
	fmr_pkg::pixel_t pix_q;
	logic            last_q;

	assign ready = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && in_valid) begin
			pix_q  <= fmr_pkg::recolor(colour);
			last_q <= last;
		end
	end

	assign out_valid  = valid_q;
	assign pixel_out  = pix_q;
	assign frame_last = last_q;

endmodule

FILE: hw/rtl/fuse_mosaic_recolor_pixels_core.sv
// Fuses two co-located ARGB pixel streams (pixel_b wins unless it is opaque
// black), replaces each pixel by the fused color of the top-left pixel of
// its block_size square block (edge blocks clipped) and maps the result
// through a fixed 18-entry palette swap table; frame_last marks the last
// pixel of each frame. Throughput is one pixel per clock while out_stall is
// low: the single-port line store takes one write (top-left pixel of a block)
// or one read (later rows) per transfer. A pixel passes the s1 register
// (registered line store read), then the palette swap into the output
// register. The user must write sizes through the cfg port only while no pixel
// is in flight (the block does not enforce this); any write to a defined
// register restarts the frame at the top-left pixel but keeps the line store.
module fuse_mosaic_recolor_pixels_core #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              cfg_wr_en,
	input  logic [fmr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fmr_pkg::CFG_DATA_W-1:0]    cfg_data,

	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [31:0]                       pixel_a,
	input  logic [31:0]                       pixel_b,

	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [31:0]                       pixel_out,
	output logic                              frame_last
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int LW = $clog2(MAX_HEIGHT);

	fmr_pkg::raster_ctl_t ctl;
	logic [CW-1:0]        blk_idx;
	logic                 accept;
	logic                 out_ready;
	logic                 cfg_restart;

	fmr_pkg::pixel_t fused;
	fmr_pkg::pixel_t held_q;
	fmr_pkg::pixel_t store_rd;

	// stage 1: line store read in flight
	logic            s1_valid_q;
	logic            line_rd_s1;
	fmr_pkg::pixel_t colour_s1;
	logic            last_s1;
	fmr_pkg::pixel_t colour_sel;

	// s1 drains into the output register whenever that register is free or
	// being emptied, so a new transfer is taken while a result waits
	assign in_stall = s1_valid_q && !out_ready;
	assign accept   = in_valid && !in_stall;

	// only a write to a defined register restarts the frame
	assign cfg_restart = cfg_wr_en && (cfg_index == fmr_pkg::REG_FRAME_WIDTH
		|| cfg_index == fmr_pkg::REG_FRAME_HEIGHT || cfg_index == fmr_pkg::REG_BLOCK_SIZE);

	assign fused = (pixel_b == fmr_pkg::OPAQUE_BLACK) ? pixel_a : pixel_b;

	fmr_raster #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.CW         (CW),
		.LW         (LW)
	) u_raster (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.adv       (accept),
		.ctl       (ctl),
		.blk_idx   (blk_idx)
	);

	// Write on the block's top-left pixel, read on its later rows. A read
	// of an entry always follows its write by at least one transfer, and
	// the write lands at its own edge, so no forwarding is needed.
	fmr_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_store (
		.clk     (clk),
		.wr_en   (accept && ctl.block_start),
		.rd_en   (accept && ctl.line_rd),
		.addr    (blk_idx),
		.wr_data (fused),
		.rd_data (store_rd)
	);

	// held color of the current block along its first row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (cfg_restart) begin
			held_q <= '0;
		end else if (accept && ctl.block_start) begin
			held_q <= fused;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (out_ready) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			line_rd_s1 <= ctl.line_rd;
			colour_s1  <= ctl.block_start ? fused : held_q;
			last_s1    <= ctl.frame_end;
		end
	end

	assign colour_sel = line_rd_s1 ? store_rd : colour_s1;

	fmr_out_stage u_out_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s1_valid_q),
		.colour     (colour_sel),
		.last       (last_s1),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.pixel_out  (pixel_out),
		.frame_last (frame_last),
		.ready      (out_ready)
	);

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_valid_q)
		else $error("accepted pixel lost before stage 1");

	a_full_pipe_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && out_valid && out_stall) |-> in_stall)
		else $error("input taken with both stages blocked");

	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && out_ready && !accept) |=> !s1_valid_q)
		else $error("stage 1 repeated a pixel");

endmodule

FILE: tb/tb_top.sv
module tb_top;

	// run limits
	localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run
	localparam int HOLD_CYCLES  = 300;     // long output hold-off that backs up the core
	localparam int DRAIN_CYCLES = 4;       // extra wait after the last expected output, as margin
	localparam int PHASE_ITEMS  = 185;     // random pixels per idle phase, four phases

	// sizes above this act as this; zero acts as one (width, height and block alike)
	localparam logic [fmr_pkg::CFG_DATA_W-1:0] DIM_MAX = 13'd4096;
	// index that decodes to no register: the write must leave everything alone
	localparam logic [fmr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// palette swap pairs, kept here independent of the package table
	localparam int PALETTE_LEN = 18;
	localparam fmr_pkg::pixel_t PALETTE_KEY [PALETTE_LEN] = '{
		32'hFF008AFF, 32'hFF646464, 32'hFF787878, 32'hFFA5A08C, 32'hFF91873C,
		32'hFF91873D, 32'hFF5A6423, 32'hFF75752F, 32'hFF784614, 32'hFF00FF00,
		32'hFF400000, 32'hFFFF0000, 32'hFF7F0000, 32'hFFFF00FF, 32'hFFD2C8A0,
		32'hFF8C460F, 32'hFFFF8000, 32'hFFDC6400
	};
	localparam fmr_pkg::pixel_t PALETTE_VAL [PALETTE_LEN] = '{
		32'hFF000000, 32'hFF404040, 32'hFF737373, 32'hFF737373, 32'hFFABABAB,
		32'hFFABABAB, 32'hFFABABAB, 32'hFFABABAB, 32'hFF8D8D8D, 32'hFFCCCCCC,
		32'hFF999999, 32'hFF999999, 32'hFFFFFFFF, 32'hFFC0C0C0, 32'hFF666666,
		32'hFF666666, 32'hFF808080, 32'hFF808080
	};

	// directed table: a row is either a register write or one pixel transfer.
	// typed rows carry the output read straight off the spec; the rest use the predictor.
	typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

	typedef struct packed {
		row_kind_t                       kind;
		logic [fmr_pkg::CFG_IDX_W-1:0]   idx;
		logic [fmr_pkg::CFG_DATA_W-1:0]  data;
		fmr_pkg::pixel_t                 a;
		fmr_pkg::pixel_t                 b;
		logic                            typed;
		fmr_pkg::pixel_t                 want_pix;
		logic                            want_last;
	} dir_row_t;

	localparam int DIR_LEN = 40;
	localparam dir_row_t DIRECTED [DIR_LEN] = '{
		// 4x2 frame, 1x1 blocks: fuse rule, field extremes, palette hits
		'{ROW_CFG, fmr_pkg::REG_BLOCK_SIZE,   13'd1, '0, '0, 1'b0, '0, 1'b0},
		'{ROW_CFG, fmr_pkg::REG_FRAME_WIDTH,  13'd4, '0, '0, 1'b0, '0, 1'b0},
		'{ROW_CFG, fmr_pkg::REG_FRAME_HEIGHT, 13'd2, '0, '0, 1'b0, '0, 1'b0},
		'{ROW_PIX, '0, '0, 32'h0000_0000, 32'hFF00_0000, 1'b1, 32'h0000_0000, 1'b0},
		'{ROW_PIX, '0, '0, 32'hFFFF_FFFF, 32'hFF00_0000, 1'b1, 32'hFFFF_FFFF, 1'b0},
		'{ROW_PIX, '0, '0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0},
		'{ROW_PIX, '0, '0, 32'h0000_0000, 32'hFF00_8AFF, 1'b1, 32'hFF00_0000, 1'b0},
		'{ROW_PIX, '0, '0, 32'hFF64_6464, 32'hFF00_0000, 1'b1, 32'hFF40_4040, 1'b0},
		'{ROW_PIX, '0, '0, 32'hFFFF_FFFF, 32'hFF7F_0000, 1'b1, 32'hFFFF_FFFF, 1'b0},
		'{ROW_PIX, '0, '0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
		'{ROW_PIX, '0, '0, 32'h0000_0000, 32'hFF00_0001, 1'b1, 32'hFF00_0001, 1'b1},
		// 2x2 blocks: held color on the first block row, line store on the second
		'{ROW_CFG, fmr_pkg::REG_BLOCK_SIZE,   13'd2, '0, '0, 1'b0, '0, 1'b0},
		'{ROW_PIX, '0, '0, 32'h1111_1111, 32'hFF00_0000, 1'b1, 32'h1111_1111, 1'b0},
		'{ROW_PIX, '0, '0, 32'h0000_0000, 32'h2222_2222, 1'b1, 32'h1111_1111, 1'b0},
		'{ROW_PIX, '0, '0, 32'h0000_0000, 32'hFF00_FF00, 1'b1, 32'hFFCC_CCCC, 1'b0},
		'{ROW_PIX, '0, '0, 32'h0000_0000, 32'h3333_3333, 1'b1, 32'hFFCC_CCCC, 1'b0},
		'{ROW_PIX, '0, '0, 32'h0000_0000, 32'h4444_4444, 1'b0, '0, 1'b0},
		'{ROW_PIX, '0, '0, 32'h0000_0000, 32'h5555_5555, 1'b0, '0, 1'b0},
		'{ROW_PIX, '0, '0, 32'h0000_0000, 32'h6666_6666, 1'b0, '0, 1'b0},
		'{ROW_PIX, '0, '0, 32'h0000_0000, 32'h7777_7777, 1'b0, '0, 1'b0},
		// restart mid-frame: rewriting the same height puts the next pixel at (0,0)
		'{ROW_PIX, '0, '0, 32'h0000_0000, 32'h8888_8888, 1'b1, 32'h8888_8888, 1'b0},
		'{ROW_CFG, fmr_pkg::REG_FRAME_HEIGHT, 13'd2, '0, '0, 1'b0, '0, 1'b0},
		'{ROW_PIX, '0, '0, 32'h0000_0000, 32'h9999_9999, 1'b1, 32'h9999_9999, 1'b0},
		// zero sizes act as one: 1x1 frames, every pixel is the last
		'{ROW_CFG, fmr_pkg::REG_FRAME_WIDTH,  13'd0, '0, '0, 1'b0, '0, 1'b0},
		'{ROW_CFG, fmr_pkg::REG_FRAME_HEIGHT, 13'd0, '0, '0, 1'b0, '0, 1'b0},
		'{ROW_PIX, '0, '0, 32'hDEAD_BEEF, 32'hFF00_0000, 1'b1, 32'hDEAD_BEEF, 1'b1},
		'{ROW_PIX, '0, '0, 32'h0000_0000, 32'hFF78_4614, 1'b1, 32'hFF8D_8D8D, 1'b1},
		// undecoded index, zero block, then everything at the top of the data range
		'{ROW_CFG, REG_UNUSED,                13'd8191, '0, '0, 1'b0, '0, 1'b0},
		'{ROW_CFG, fmr_pkg::REG_BLOCK_SIZE,   13'd0,    '0, '0, 1'b0, '0, 1'b0},
		'{ROW_CFG, fmr_pkg::REG_FRAME_WIDTH,  13'd8191, '0, '0, 1'b0, '0, 1'b0},
		'{ROW_CFG, fmr_pkg::REG_FRAME_HEIGHT, 13'd8191, '0, '0, 1'b0, '0, 1'b0},
		'{ROW_CFG, fmr_pkg::REG_BLOCK_SIZE,   13'd8191, '0, '0, 1'b0, '0, 1'b0},
		'{ROW_PIX, '0, '0, 32'h0000_0000, 32'hFFDC_6400, 1'b1, 32'hFF80_8080, 1'b0},
		'{ROW_PIX, '0, '0, 32'h0000_0000, 32'h1234_5678, 1'b1, 32'hFF80_8080, 1'b0},
		'{ROW_CFG, fmr_pkg::REG_BLOCK_SIZE,   13'd4096, '0, '0, 1'b0, '0, 1'b0},
		'{ROW_PIX, '0, '0, 32'hABCD_EF01, 32'hFF00_0000, 1'b1, 32'hABCD_EF01, 1'b0},
		'{ROW_CFG, fmr_pkg::REG_FRAME_WIDTH,  13'd4096, '0, '0, 1'b0, '0, 1'b0},
		'{ROW_PIX, '0, '0, 32'h0000_0000, 32'hFF8C_460F, 1'b1, 32'hFF66_6666, 1'b0},
		// undecoded write mid-frame: no restart, still inside the same block
		'{ROW_CFG, REG_UNUSED,                13'd0, '0, '0, 1'b0, '0, 1'b0},
		'{ROW_PIX, '0, '0, 32'h0000_0000, 32'h0102_0304, 1'b1, 32'hFF66_6666, 1'b0}
	};

	typedef enum int {PH_STEADY, PH_SEND_GAPS, PH_RECV_STALLS, PH_BOTH} idle_phase_t;

	typedef struct packed {
		fmr_pkg::pixel_t pix;
		logic            last;
	} mosaic_out_t;

	// DUT ports
	logic                            clk;
	logic                            arst_n      = 1'b0;
	logic                            cfg_wr_en   = 1'b0;
	logic [fmr_pkg::CFG_IDX_W-1:0]   cfg_index   = '0;
	logic [fmr_pkg::CFG_DATA_W-1:0]  cfg_data    = '0;
	logic                            in_valid    = 1'b0;
	logic                            in_stall;
	logic [31:0]                     pixel_a     = '0;
	logic [31:0]                     pixel_b     = '0;
	logic                            out_valid;
	logic                            out_stall   = 1'b0;
	logic [31:0]                     pixel_out;
	logic                            frame_last;

	fuse_mosaic_recolor_pixels_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pixel_a    (pixel_a),
		.pixel_b    (pixel_b),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_out  (pixel_out),
		.frame_last (frame_last)
	);

	// mosaic predictor state, reset values
	logic [fmr_pkg::CFG_DATA_W-1:0]  width_reg  = 13'(fmr_pkg::RST_FRAME_WIDTH);
	logic [fmr_pkg::CFG_DATA_W-1:0]  height_reg = 13'(fmr_pkg::RST_FRAME_HEIGHT);
	logic [fmr_pkg::CFG_DATA_W-1:0]  block_reg  = 13'(fmr_pkg::RST_BLOCK_SIZE);
	logic [11:0]                     raster_col = '0;
	logic [11:0]                     raster_row = '0;
	logic [11:0]                     blk_dx     = '0;
	logic [11:0]                     blk_dy     = '0;
	logic [11:0]                     blk_col    = '0;
	fmr_pkg::pixel_t                 held_color = '0;
	fmr_pkg::pixel_t                 color_line [4096];

	mosaic_out_t            pending_out [$];   // predicted outputs, oldest first
	mosaic_out_t            out_head;
	int                     mismatch_count = 0;
	int                     cycle_count    = 0;

	// traffic shaping: rates and hold_trigger set by the stimulus process, hold_seen/hold_left by the receiver
	int                     send_gap_pct   = 0;
	int                     recv_stall_pct = 0;
	int                     hold_trigger   = 0;
	int                     hold_seen      = 0;
	int                     hold_left      = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic [fmr_pkg::CFG_DATA_W-1:0] eff_dim(
			input logic [fmr_pkg::CFG_DATA_W-1:0] v);
		if (v == '0)
			return 13'd1;
		if (v > DIM_MAX)
			return DIM_MAX;
		return v;
	endfunction

	function automatic fmr_pkg::pixel_t palette_swap(input fmr_pkg::pixel_t c);
		for (int i = 0; i < PALETTE_LEN; i++)
			if (PALETTE_KEY[i] == c)
				return PALETTE_VAL[i];
		return c;
	endfunction

	// any decoded write restarts the frame; the line store survives
	task automatic restart_raster();
		raster_col = '0;
		raster_row = '0;
		blk_dx     = '0;
		blk_dy     = '0;
		blk_col    = '0;
		held_color = '0;
	endtask

	task automatic apply_config(input logic [fmr_pkg::CFG_IDX_W-1:0] idx,
			input logic [fmr_pkg::CFG_DATA_W-1:0] val);
		case (idx)
			fmr_pkg::REG_FRAME_WIDTH:  width_reg  = val;
			fmr_pkg::REG_FRAME_HEIGHT: height_reg = val;
			fmr_pkg::REG_BLOCK_SIZE:   block_reg  = val;
			default:                   return;
		endcase
		restart_raster();
	endtask

	// one accepted pixel pair -> the output pixel it produces; advances the raster
	task automatic predict_pixel(input fmr_pkg::pixel_t a, input fmr_pkg::pixel_t b,
			output fmr_pkg::pixel_t pix, output logic last);
		logic [fmr_pkg::CFG_DATA_W-1:0]  w;
		logic [fmr_pkg::CFG_DATA_W-1:0]  h;
		logic [fmr_pkg::CFG_DATA_W-1:0]  bs;
		fmr_pkg::pixel_t                 fused;
		fmr_pkg::pixel_t                 color;
		logic                            line_end;
		w     = eff_dim(width_reg);
		h     = eff_dim(height_reg);
		bs    = eff_dim(block_reg);
		fused = (b == fmr_pkg::OPAQUE_BLACK) ? a : b;

		if (blk_dy == '0) begin
			// first row of a block row: top-left pixel sets the color and fills the store
			if (blk_dx == '0) begin
				held_color          = fused;
				color_line[blk_col] = fused;
			end
			color = held_color;
		end else begin
			color = color_line[blk_col];
		end

		line_end = ({1'b0, raster_col} + 13'd1 >= w);
		last     = line_end && ({1'b0, raster_row} + 13'd1 >= h);
		pix      = palette_swap(color);

		if (last) begin
			restart_raster();
		end else if (line_end) begin
			raster_col = '0;
			blk_dx     = '0;
			blk_col    = '0;
			raster_row = raster_row + 1'b1;
			blk_dy     = ({1'b0, blk_dy} + 13'd1 >= bs) ? '0 : blk_dy + 1'b1;
		end else begin
			raster_col = raster_col + 1'b1;
			if ({1'b0, blk_dx} + 13'd1 >= bs) begin
				blk_dx  = '0;
				blk_col = blk_col + 1'b1;
			end else begin
				blk_dx = blk_dx + 1'b1;
			end
		end
	endtask

	// ---------------------------------------------------------------- drivers

	// inputs change on the falling edge; a transfer is seen on the rising edge
	task automatic send_pixel(input fmr_pkg::pixel_t a, input fmr_pkg::pixel_t b,
			input logic typed, input fmr_pkg::pixel_t want_pix, input logic want_last);
		mosaic_out_t        item;
		fmr_pkg::pixel_t    pred_pix;
		logic               pred_last;
		@(negedge clk);
		// sender gaps are decided before valid rises; once up it holds until the transfer
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pixel_a  <= a;
		pixel_b  <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		// the predictor always runs so its raster state tracks the core
		predict_pixel(a, b, pred_pix, pred_last);
		item.pix  = typed ? want_pix  : pred_pix;
		item.last = typed ? want_last : pred_last;
		pending_out.push_back(item);
	endtask

	// drop valid and let every in-flight pixel come out before touching registers
	task automatic quiesce();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_out.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [fmr_pkg::CFG_IDX_W-1:0] idx,
			input logic [fmr_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		apply_config(idx, val);
	endtask

	// ---------------------------------------------------------------- random content

	// mostly small sizes so frames wrap often; now and then zero or the top of the range
	function automatic logic [fmr_pkg::CFG_DATA_W-1:0] pick_dim(input int small_max);
		case ($urandom_range(0, 19))
			0:       return '0;
			1:       return DIM_MAX;
			2:       return 13'd8191;
			3:       return 13'($urandom_range(1, 8191));
			default: return 13'($urandom_range(1, small_max));
		endcase
	endfunction

	// palette keys show up often, so swaps hit even after the mosaic thins them out
	function automatic fmr_pkg::pixel_t pick_color();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return PALETTE_KEY[$urandom_range(0, PALETTE_LEN - 1)];
			4:          return '0;
			5:          return '1;
			default:    return $urandom;
		endcase
	endfunction

	task automatic random_config();
		if ($urandom_range(0, 7) == 0)
			return;  // keep the current frame going
		if ($urandom_range(0, 3) != 0)
			write_reg(fmr_pkg::REG_FRAME_WIDTH, pick_dim(12));
		if ($urandom_range(0, 3) != 0)
			write_reg(fmr_pkg::REG_FRAME_HEIGHT, pick_dim(5));
		if ($urandom_range(0, 3) != 0)
			write_reg(fmr_pkg::REG_BLOCK_SIZE, pick_dim(6));
		if ($urandom_range(0, 9) == 0)
			write_reg(REG_UNUSED, 13'($urandom_range(0, 8191)));
	endtask

	// ---------------------------------------------------------------- receiver

	// output stall: a long hold-off when asked, otherwise random at the phase rate
	always @(negedge clk) begin
		if (hold_seen != hold_trigger) begin
			hold_seen = hold_trigger;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("cycle %0d: %s mismatch, got %h want %h", cycle_count, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (pending_out.size() == 0) begin
				report_mismatch("unexpected output transfer", pixel_out, '0);
			end else begin
				out_head = pending_out.pop_front();
				if (pixel_out !== out_head.pix)
					report_mismatch("pixel_out", pixel_out, out_head.pix);
				if (frame_last !== out_head.last)
					report_mismatch("frame_last", 32'(frame_last), 32'(out_head.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------- stimulus

	initial begin
		fmr_pkg::pixel_t a;
		fmr_pkg::pixel_t b;
		int              phase_items;
		int              seg_len;
		logic            press_done;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table, default traffic: no gaps, no stalls
		for (int r = 0; r < DIR_LEN; r++) begin
			if (DIRECTED[r].kind == ROW_CFG) begin
				quiesce();
				write_reg(DIRECTED[r].idx, DIRECTED[r].data);
			end else begin
				send_pixel(DIRECTED[r].a, DIRECTED[r].b, DIRECTED[r].typed,
					DIRECTED[r].want_pix, DIRECTED[r].want_last);
			end
		end

		// random segments: each one drains, picks new sizes (or keeps them), streams pixels
		press_done = 1'b0;
		for (int p = 0; p < 4; p++) begin
			case (idle_phase_t'(p))
				PH_STEADY:      begin send_gap_pct = 0;  recv_stall_pct = 0;  end
				PH_SEND_GAPS:   begin send_gap_pct = 77; recv_stall_pct = 0;  end
				PH_RECV_STALLS: begin send_gap_pct = 0;  recv_stall_pct = 77; end
				default:        begin send_gap_pct = 33; recv_stall_pct = 33; end
			endcase
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				quiesce();
				random_config();
				seg_len = $urandom_range(8, 40);
				// back-pressure: output held off while the sender keeps offering
				if (!press_done && idle_phase_t'(p) == PH_STEADY) begin
					hold_trigger = hold_trigger + 1;
					seg_len      = 40;
					press_done   = 1'b1;
				end
				repeat (seg_len) begin
					a = pick_color();
					b = ($urandom_range(0, 9) < 3) ? fmr_pkg::OPAQUE_BLACK : pick_color();
					send_pixel(a, b, 1'b0, '0, 1'b0);
				end
				phase_items += seg_len;
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_out.size() != 0)
			@(posedge clk);
		repeat (2 * DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: fuse_mosaic_recolor_pixels_core.f
hw/rtl/fmr_pkg.sv
hw/rtl/fmr_line_store.sv
hw/rtl/fmr_raster.sv
hw/rtl/fmr_out_stage.sv
hw/rtl/fuse_mosaic_recolor_pixels_core.sv
tb/tb_top.sv
